>>> rtl/core/utf8_serial_field_validator_macros.svh
// Assertion macros shared by the serial field validator RTL.
// Depends on nothing; expects clk and rst_n in the including module's scope.
`ifndef UTF8_SERIAL_FIELD_VALIDATOR_MACROS_SVH
`define UTF8_SERIAL_FIELD_VALIDATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define UTF8SV_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define UTF8SV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/utf8sv_pkg.sv
// Types, constants and helper functions for the UTF-8 serial field validator.
// Used by utf8sv_step and utf8_serial_field_validator; depends on nothing.
package utf8sv_pkg;

    localparam int CP_W = 21;

    localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO      = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI      = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_DEL       = 21'h00007F;
    localparam logic [CP_W-1:0] CP_FIRST_OK  = 21'h000020;
    localparam logic [CP_W-1:0] SP_ASCII     = 21'h000020;
    localparam logic [CP_W-1:0] SP_NEL       = 21'h000085;
    localparam logic [CP_W-1:0] SP_NBSP      = 21'h0000A0;
    localparam logic [CP_W-1:0] SP_OGHAM     = 21'h001680;
    localparam logic [CP_W-1:0] SP_RANGE_LO  = 21'h002000;
    localparam logic [CP_W-1:0] SP_RANGE_HI  = 21'h00200A;
    localparam logic [CP_W-1:0] SP_LINE_SEP  = 21'h002028;
    localparam logic [CP_W-1:0] SP_PARA_SEP  = 21'h002029;
    localparam logic [CP_W-1:0] SP_NNBSP     = 21'h00202F;
    localparam logic [CP_W-1:0] SP_MMSP      = 21'h00205F;
    localparam logic [CP_W-1:0] SP_IDEO      = 21'h003000;

    localparam logic [7:0] LEAD2_LO = 8'hC2;
    localparam logic [7:0] LEAD2_HI = 8'hDF;
    localparam logic [7:0] LEAD3_LO = 8'hE0;
    localparam logic [7:0] LEAD3_HI = 8'hEF;
    localparam logic [7:0] LEAD4_LO = 8'hF0;
    localparam logic [7:0] LEAD4_HI = 8'hF4;

    // Overlong floor codes.
    typedef enum logic [1:0] {
        FLOOR_NONE = 2'd0,
        FLOOR_2B   = 2'd1,
        FLOOR_3B   = 2'd2,
        FLOOR_4B   = 2'd3
    } floor_code_t;

    // Running decode state of one field, without the byte position.
    typedef struct packed {
        logic [1:0]      bytes_pending;
        logic [CP_W-1:0] partial_code_point;
        floor_code_t     overlong_floor;
        logic            terminator_seen;
        logic            record_error;
        logic            content_seen;
        logic            first_is_space;
        logic            last_is_space;
    } field_state_t;

    function automatic logic [CP_W-1:0] floor_value(input floor_code_t code);
        logic [CP_W-1:0] v;
        case (code)
            FLOOR_NONE: v = 21'h000000;
            FLOOR_2B:   v = 21'h000080;
            FLOOR_3B:   v = 21'h000800;
            FLOOR_4B:   v = 21'h010000;
            default:    v = 21'h000000;
        endcase
        return v;
    endfunction

    function automatic logic is_space(input logic [CP_W-1:0] cp);
        return (cp == SP_ASCII) || (cp == SP_NEL) || (cp == SP_NBSP) ||
               (cp == SP_OGHAM) || ((cp >= SP_RANGE_LO) && (cp <= SP_RANGE_HI)) ||
               (cp == SP_LINE_SEP) || (cp == SP_PARA_SEP) || (cp == SP_NNBSP) ||
               (cp == SP_MMSP) || (cp == SP_IDEO);
    endfunction

endpackage

>>> rtl/core/utf8_serial_field_validator.sv
// UTF-8 serial-number field validator: input register, state update, result register.
// Depends on utf8sv_pkg, utf8sv_step and utf8_serial_field_validator_macros.svh.
//
// The block takes a NUL-padded serial field of FIELD_BYTES bytes, one byte per
// transaction on the serial_byte channel, counts its own place in the field and
// delivers exactly one transaction on the result channel after the last byte of
// each field: serial_valid is 1 when the text is nonempty, ends in a NUL before
// the field is full, has only zero bytes after that NUL, is well-formed UTF-8
// (no bad leads, no overlong forms, no surrogates, nothing above U+10FFFF), holds
// no C0 control characters or DEL, and neither starts nor ends with a Unicode space.
// Throughput is one byte per clock cycle while byte_ready is high: each byte
// passes through an input register and an update of the running decode state,
// and the verdict goes to the result register when the last byte leaves the
// input register. byte_ready drops only when the last byte of a field waits in
// the input register while the previous result still sits untaken in the result
// register. No clearing pass is needed after reset.
module utf8_serial_field_validator #(
    parameter int FIELD_BYTES = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] serial_byte,
    input  logic       byte_valid,
    output logic       byte_ready,
    output logic       serial_valid,
    output logic       result_valid,
    input  logic       result_ready
);

    `include "utf8_serial_field_validator_macros.svh"

    localparam int             POS_W    = $clog2(FIELD_BYTES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FIELD_BYTES - 1);

    // Input register.
    logic       in_full_reg, in_full_next;
    logic [7:0] in_byte_reg;

    // Field state.
    logic [POS_W-1:0]         pos_reg, pos_next;
    utf8sv_pkg::field_state_t state_reg, state_next;
    utf8sv_pkg::field_state_t step_state;

    // Result register.
    logic out_full_reg, out_full_next;
    logic out_bit_reg, out_bit_next;

    logic is_last;
    logic advance;
    logic take_in;
    logic field_ok;

    utf8sv_step u_step (
        .cur       (state_reg),
        .data_byte (in_byte_reg),
        .nxt       (step_state)
    );

    assign is_last = (pos_reg == POS_LAST);

    // Hold the last byte of a field until the result register has room.
    assign advance    = in_full_reg && (!is_last || !out_full_reg || result_ready);
    assign byte_ready = !in_full_reg || advance;
    assign take_in    = byte_valid && byte_ready;

    // Final verdict, counting a missing terminator as a failure.
    assign field_ok = !step_state.record_error && step_state.terminator_seen &&
                      !step_state.first_is_space && !step_state.last_is_space;

    always_comb
    begin
        in_full_next  = take_in ? 1'b1 : (advance ? 1'b0 : in_full_reg);
        pos_next      = pos_reg;
        state_next    = state_reg;
        out_full_next = (out_full_reg && !result_ready);
        out_bit_next  = out_bit_reg;

        if (advance)
        begin
            if (is_last)
            begin
                // Emit the verdict and clear for the next field.
                pos_next      = {POS_W{1'b0}};
                state_next    = '0;
                out_full_next = 1'b1;
                out_bit_next  = field_ok;
            end
            else
            begin
                pos_next   = pos_reg + POS_W'(1);
                state_next = step_state;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            pos_reg      <= {POS_W{1'b0}};
            state_reg    <= '0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg  <= in_full_next;
            pos_reg      <= pos_next;
            state_reg    <= state_next;
            out_full_reg <= out_full_next;
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        if (take_in)
            in_byte_reg <= serial_byte;
        out_bit_reg <= out_bit_next;
    end

    assign result_valid = out_full_reg;
    assign serial_valid = out_bit_reg;

    `UTF8SV_ASSERT_IMPLY(a_pos_in_range, 1'b1, pos_reg <= POS_LAST,
        "byte position ran past the end of the field")
    `UTF8SV_ASSERT_NEXT(a_last_byte_holds,
        in_full_reg && is_last && out_full_reg && !result_ready,
        in_full_reg && $stable(pos_reg) && out_full_reg,
        "last byte advanced while the result register was still occupied")
    `UTF8SV_ASSERT_NEXT(a_field_wraps, advance && is_last,
        out_full_reg && (pos_reg == {POS_W{1'b0}}) && !state_reg.record_error,
        "field end did not produce a result and clear the state")
    `UTF8SV_ASSERT_IMPLY(a_no_pending_after_nul, state_reg.bytes_pending != 2'd0,
        !state_reg.terminator_seen,
        "continuation bytes pending after the terminator")

endmodule

>>> rtl/core/utf8sv_step.sv
// Per-byte UTF-8 decode and field-rule update (combinational).
// Depends on utf8sv_pkg.
module utf8sv_step (
    input  utf8sv_pkg::field_state_t cur,
    input  logic [7:0]               data_byte,
    output utf8sv_pkg::field_state_t nxt
);

    logic                          finish;
    logic [utf8sv_pkg::CP_W-1:0]   fin_cp;
    utf8sv_pkg::floor_code_t       fin_floor;
    logic [utf8sv_pkg::CP_W-1:0]   shifted_cp;
    logic                          cp_bad;
    logic                          cp_space;

    assign shifted_cp = {cur.partial_code_point[utf8sv_pkg::CP_W-7:0], data_byte[5:0]};

    always_comb
    begin
        nxt       = cur;
        finish    = 1'b0;
        fin_cp    = {(utf8sv_pkg::CP_W){1'b0}};
        fin_floor = cur.overlong_floor;

        if (cur.terminator_seen)
        begin
            // Padding must stay zero.
            if (data_byte != 8'h00)
                nxt.record_error = 1'b1;
        end
        else if (data_byte == 8'h00)
        begin
            nxt.terminator_seen = 1'b1;
            if ((cur.bytes_pending != 2'd0) || !cur.content_seen)
                nxt.record_error = 1'b1;
            nxt.bytes_pending = 2'd0;
        end
        else if (cur.bytes_pending != 2'd0)
        begin
            if (data_byte[7:6] != 2'b10)
            begin
                // Drop the pending sequence.
                nxt.record_error       = 1'b1;
                nxt.bytes_pending      = 2'd0;
                nxt.partial_code_point = {(utf8sv_pkg::CP_W){1'b0}};
            end
            else
            begin
                nxt.partial_code_point = shifted_cp;
                nxt.bytes_pending      = cur.bytes_pending - 2'd1;
                if (cur.bytes_pending == 2'd1)
                begin
                    finish = 1'b1;
                    fin_cp = shifted_cp;
                end
            end
        end
        else if (!data_byte[7])
        begin
            nxt.overlong_floor = utf8sv_pkg::FLOOR_NONE;
            fin_floor          = utf8sv_pkg::FLOOR_NONE;
            finish             = 1'b1;
            fin_cp             = {13'd0, data_byte};
        end
        else if ((data_byte >= utf8sv_pkg::LEAD2_LO) && (data_byte <= utf8sv_pkg::LEAD2_HI))
        begin
            nxt.partial_code_point = {16'd0, data_byte[4:0]};
            nxt.bytes_pending      = 2'd1;
            nxt.overlong_floor     = utf8sv_pkg::FLOOR_2B;
        end
        else if ((data_byte >= utf8sv_pkg::LEAD3_LO) && (data_byte <= utf8sv_pkg::LEAD3_HI))
        begin
            nxt.partial_code_point = {17'd0, data_byte[3:0]};
            nxt.bytes_pending      = 2'd2;
            nxt.overlong_floor     = utf8sv_pkg::FLOOR_3B;
        end
        else if ((data_byte >= utf8sv_pkg::LEAD4_LO) && (data_byte <= utf8sv_pkg::LEAD4_HI))
        begin
            nxt.partial_code_point = {18'd0, data_byte[2:0]};
            nxt.bytes_pending      = 2'd3;
            nxt.overlong_floor     = utf8sv_pkg::FLOOR_4B;
        end
        else
        begin
            nxt.record_error = 1'b1;
        end

        cp_bad = (fin_cp < utf8sv_pkg::floor_value(fin_floor)) ||
                 (fin_cp > utf8sv_pkg::CP_MAX) ||
                 ((fin_cp >= utf8sv_pkg::SURR_LO) && (fin_cp <= utf8sv_pkg::SURR_HI)) ||
                 (fin_cp < utf8sv_pkg::CP_FIRST_OK) ||
                 (fin_cp == utf8sv_pkg::CP_DEL);
        cp_space = utf8sv_pkg::is_space(fin_cp);

        if (finish)
        begin
            if (cp_bad)
                nxt.record_error = 1'b1;
            else
            begin
                if (!cur.content_seen)
                begin
                    nxt.first_is_space = cp_space;
                    nxt.content_seen   = 1'b1;
                end
                nxt.last_is_space = cp_space;
            end
        end
    end

endmodule
